// File: src/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants for the stroke map statistics block
// Coordinate, length and count widths, the operation record passed from the
// front end to the back end, and the state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

  localparam int COORD_BITS  = 24;
  localparam int LENGTH_BITS = 40;
  localparam int COUNT_BITS  = 20;

  // A segment root is at most sqrt(2) * 2^COORD_BITS, so one bit more.
  localparam int ROOT_BITS   = COORD_BITS + 1;
  // Radicand padded to an even number of bits for the two-bit-per-step root.
  localparam int RAD_BITS    = 2 * ROOT_BITS;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int ITER_BITS   = $clog2(ROOT_BITS);
  localparam int SUM_BITS    = ((LENGTH_BITS > ROOT_BITS) ? LENGTH_BITS : ROOT_BITS) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic {
    OP_SEG,
    OP_END
  } op_kind_t;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_MANY
  } seen_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_ROOT,
    B_ACC
  } back_state_t;

  // One queued operation: a segment (dx, dy) or a map end with its totals.
  typedef struct packed {
    op_kind_t                      kind;
    logic [COORD_BITS-1:0]         dx;
    logic [COORD_BITS-1:0]         dy;
    logic [COUNT_BITS-1:0]         count;
    logic                          found;
    logic signed [COORD_BITS-1:0]  min_x;
    logic signed [COORD_BITS-1:0]  min_y;
    logic signed [COORD_BITS-1:0]  max_x;
    logic signed [COORD_BITS-1:0]  max_y;
  } op_t;

endpackage

`default_nettype wire

// File: src/sms_if.sv
// ----------------------------------------------------------------------------
// sms interfaces: point and totals channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  has_point;
  logic signed [sms_pkg::COORD_BITS-1:0] x_coord;
  logic signed [sms_pkg::COORD_BITS-1:0] y_coord;
  logic                                  stroke_start;
  logic                                  stroke_end;
  logic                                  stroke_closed;
  logic                                  map_end;

  modport source (output valid, has_point, x_coord, y_coord, stroke_start, stroke_end,
                  stroke_closed, map_end, input ready);
  modport sink   (input valid, has_point, x_coord, y_coord, stroke_start, stroke_end,
                  stroke_closed, map_end, output ready);
endinterface

interface sms_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [sms_pkg::COUNT_BITS-1:0]        point_total;
  logic [sms_pkg::LENGTH_BITS-1:0]       length_total;
  logic                                  box_found;
  logic signed [sms_pkg::COORD_BITS-1:0] box_min_x;
  logic signed [sms_pkg::COORD_BITS-1:0] box_min_y;
  logic signed [sms_pkg::COORD_BITS-1:0] box_max_x;
  logic signed [sms_pkg::COORD_BITS-1:0] box_max_y;

  modport source (output valid, point_total, length_total, box_found, box_min_x, box_min_y,
                  box_max_x, box_max_y, input ready);
  modport sink   (input valid, point_total, length_total, box_found, box_min_x, box_min_y,
                  box_max_x, box_max_y, output ready);
endinterface

`default_nettype wire

// File: src/sms_front.sv
// ----------------------------------------------------------------------------
// sms_front: point intake and classification
// Tracks the stroke, point count and bounding box, and turns each beat into
// segment and map-end operations for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_front (
  input  wire logic    clk,
  input  wire logic    rst,
  sms_in_if.sink       points,
  output sms_pkg::op_t push_op,
  output logic         push_valid,
  input  wire logic    queue_full
);

  logic signed [sms_pkg::COORD_BITS-1:0] prev_x, prev_y, first_x, first_y;
  sms_pkg::seen_t                        seen;
  logic [sms_pkg::COUNT_BITS-1:0]        point_count;
  logic signed [sms_pkg::COORD_BITS-1:0] min_x_seen, min_y_seen, max_x_seen, max_y_seen;
  logic                                  any_point_seen;

  logic         pend_seg1, pend_seg2, pend_end;
  sms_pkg::op_t seg1_op, seg2_op, end_op;

  logic                                  accept, push_fire;
  logic                                  start_eff, is_seg1, is_seg2;
  logic [sms_pkg::COUNT_BITS-1:0]        count_upd;
  logic signed [sms_pkg::COORD_BITS-1:0] min_x_upd, min_y_upd, max_x_upd, max_y_upd;
  logic                                  found_upd;
  sms_pkg::op_t                          seg1_new, seg2_new, end_new;

  function automatic logic [sms_pkg::COORD_BITS-1:0] abs_diff(
    input logic signed [sms_pkg::COORD_BITS-1:0] a,
    input logic signed [sms_pkg::COORD_BITS-1:0] b
  );
    logic signed [sms_pkg::COORD_BITS:0] d;
    d = {a[sms_pkg::COORD_BITS-1], a} - {b[sms_pkg::COORD_BITS-1], b};
    if (d < 0) begin
      d = -d;
    end
    return d[sms_pkg::COORD_BITS-1:0];
  endfunction

  assign points.ready = !rst && !(pend_seg1 || pend_seg2 || pend_end);
  assign accept       = points.valid && points.ready;
  assign push_valid   = pend_seg1 || pend_seg2 || pend_end;
  assign push_fire    = push_valid && !queue_full;

  always_comb begin
    if (pend_seg1) begin
      push_op = seg1_op;
    end else if (pend_seg2) begin
      push_op = seg2_op;
    end else begin
      push_op = end_op;
    end
  end

  always_comb begin
    start_eff = points.stroke_start || (seen == sms_pkg::SEEN_NONE);
    is_seg1   = points.has_point && !start_eff;
    is_seg2   = is_seg1 && points.stroke_end && points.stroke_closed;

    seg1_new       = '0;
    seg1_new.kind  = sms_pkg::OP_SEG;
    seg1_new.dx    = abs_diff(prev_x, points.x_coord);
    seg1_new.dy    = abs_diff(prev_y, points.y_coord);
    seg2_new       = '0;
    seg2_new.kind  = sms_pkg::OP_SEG;
    seg2_new.dx    = abs_diff(points.x_coord, first_x);
    seg2_new.dy    = abs_diff(points.y_coord, first_y);

    count_upd = point_count;
    min_x_upd = min_x_seen;
    min_y_upd = min_y_seen;
    max_x_upd = max_x_seen;
    max_y_upd = max_y_seen;
    found_upd = any_point_seen;
    if (points.has_point) begin
      if (point_count != sms_pkg::COUNT_MAX) begin
        count_upd = point_count + 1'b1;
      end
      if (points.x_coord < min_x_seen) min_x_upd = points.x_coord;
      if (points.y_coord < min_y_seen) min_y_upd = points.y_coord;
      if (points.x_coord > max_x_seen) max_x_upd = points.x_coord;
      if (points.y_coord > max_y_seen) max_y_upd = points.y_coord;
      found_upd = 1'b1;
    end

    end_new       = '0;
    end_new.kind  = sms_pkg::OP_END;
    end_new.count = count_upd;
    end_new.found = found_upd;
    if (found_upd) begin
      end_new.min_x = min_x_upd;
      end_new.min_y = min_y_upd;
      end_new.max_x = max_x_upd;
      end_new.max_y = max_y_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_seg1      <= 1'b0;
      pend_seg2      <= 1'b0;
      pend_end       <= 1'b0;
      seen           <= sms_pkg::SEEN_NONE;
      prev_x         <= '0;
      prev_y         <= '0;
      first_x        <= '0;
      first_y        <= '0;
      point_count    <= '0;
      min_x_seen     <= sms_pkg::COORD_MAXV;
      min_y_seen     <= sms_pkg::COORD_MAXV;
      max_x_seen     <= sms_pkg::COORD_MINV;
      max_y_seen     <= sms_pkg::COORD_MINV;
      any_point_seen <= 1'b0;
    end else if (accept) begin
      pend_seg1 <= is_seg1;
      pend_seg2 <= is_seg2;
      pend_end  <= points.map_end;
      seg1_op   <= seg1_new;
      seg2_op   <= seg2_new;
      end_op    <= end_new;
      if (points.map_end) begin
        seen           <= sms_pkg::SEEN_NONE;
        prev_x         <= '0;
        prev_y         <= '0;
        first_x        <= '0;
        first_y        <= '0;
        point_count    <= '0;
        min_x_seen     <= sms_pkg::COORD_MAXV;
        min_y_seen     <= sms_pkg::COORD_MAXV;
        max_x_seen     <= sms_pkg::COORD_MINV;
        max_y_seen     <= sms_pkg::COORD_MINV;
        any_point_seen <= 1'b0;
      end else if (points.has_point) begin
        prev_x <= points.x_coord;
        prev_y <= points.y_coord;
        if (start_eff) begin
          first_x <= points.x_coord;
          first_y <= points.y_coord;
        end
        if (points.stroke_end) begin
          seen <= sms_pkg::SEEN_NONE;
        end else if (start_eff) begin
          seen <= sms_pkg::SEEN_ONE;
        end else begin
          seen <= sms_pkg::SEEN_MANY;
        end
        point_count    <= count_upd;
        min_x_seen     <= min_x_upd;
        min_y_seen     <= min_y_upd;
        max_x_seen     <= max_x_upd;
        max_y_seen     <= max_y_upd;
        any_point_seen <= found_upd;
      end
    end else if (push_fire) begin
      if (pend_seg1) begin
        pend_seg1 <= 1'b0;
      end else if (pend_seg2) begin
        pend_seg2 <= 1'b0;
      end else begin
        pend_end <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sms_queue.sv
// ----------------------------------------------------------------------------
// sms_queue: operation queue between front and back end
// A small first-in first-out store in flip-flops; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sms_pkg::op_t  push_op,
  output logic               full,
  input  wire logic          pop,
  output sms_pkg::op_t       head_op,
  output logic               not_empty
);

  sms_pkg::op_t                 entries [sms_pkg::QUEUE_DEPTH];
  logic [sms_pkg::QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [sms_pkg::QPTR_BITS:0]   fill;
  logic                          do_push, do_pop;

  assign full      = (fill == (sms_pkg::QPTR_BITS+1)'(sms_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head_op   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sms_back.sv
// ----------------------------------------------------------------------------
// sms_back: segment length unit and totals output
// Squares the deltas, takes the integer square root two radicand bits per
// cycle, adds it to the saturating length sum, and presents totals at map end.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sms_pkg::op_t  head_op,
  input  wire logic          head_valid,
  output logic               pop,
  sms_out_if.source          totals
);

  sms_pkg::back_state_t state, state_next;

  logic [2*sms_pkg::COORD_BITS-1:0] sq_x, sq_y;
  logic [sms_pkg::RAD_BITS-1:0]     rad;
  logic [sms_pkg::REM_BITS-1:0]     rem;
  logic [sms_pkg::ROOT_BITS-1:0]    root;
  logic [sms_pkg::ITER_BITS-1:0]    iter;
  logic [sms_pkg::LENGTH_BITS-1:0]  length_sum;

  logic                             out_valid, out_free;
  logic                             take_seg, take_end;
  logic [sms_pkg::REM_BITS-1:0]     rem_sh, trial;
  logic                             root_bit;
  logic [sms_pkg::SUM_BITS-1:0]     sum;

  assign out_free = !out_valid || totals.ready;
  assign take_seg = (state == sms_pkg::B_IDLE) && head_valid && (head_op.kind == sms_pkg::OP_SEG);
  assign take_end = (state == sms_pkg::B_IDLE) && head_valid && (head_op.kind == sms_pkg::OP_END)
                    && out_free;
  assign pop      = take_seg || take_end;

  assign rem_sh   = {rem[sms_pkg::REM_BITS-3:0], rad[sms_pkg::RAD_BITS-1 -: 2]};
  assign trial    = {root, 2'b01};
  assign root_bit = (rem_sh >= trial);
  assign sum      = sms_pkg::SUM_BITS'(length_sum) + sms_pkg::SUM_BITS'(root);

  always_comb begin
    state_next = state;
    case (state)
      sms_pkg::B_IDLE: begin
        if (take_seg) state_next = sms_pkg::B_SUM;
      end
      sms_pkg::B_SUM:  state_next = sms_pkg::B_ROOT;
      sms_pkg::B_ROOT: begin
        if (iter == '0) state_next = sms_pkg::B_ACC;
      end
      sms_pkg::B_ACC:  state_next = sms_pkg::B_IDLE;
      default:         state_next = sms_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sms_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (totals.ready) begin
        out_valid <= 1'b0;
      end
      if (take_end) begin
        out_valid           <= 1'b1;
        totals.point_total  <= head_op.count;
        totals.length_total <= length_sum;
        totals.box_found    <= head_op.found;
        totals.box_min_x    <= head_op.min_x;
        totals.box_min_y    <= head_op.min_y;
        totals.box_max_x    <= head_op.max_x;
        totals.box_max_y    <= head_op.max_y;
        length_sum          <= '0;
      end
      if (state == sms_pkg::B_ACC) begin
        if (sum > sms_pkg::SUM_BITS'(sms_pkg::LENGTH_MAX)) begin
          length_sum <= sms_pkg::LENGTH_MAX;
        end else begin
          length_sum <= sum[sms_pkg::LENGTH_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sms_pkg::B_IDLE: begin
        if (take_seg) begin
          sq_x <= head_op.dx * head_op.dx;
          sq_y <= head_op.dy * head_op.dy;
        end
      end
      sms_pkg::B_SUM: begin
        rad  <= sms_pkg::RAD_BITS'(sq_x) + sms_pkg::RAD_BITS'(sq_y);
        rem  <= '0;
        root <= '0;
        iter <= sms_pkg::ITER_BITS'(sms_pkg::ROOT_BITS - 1);
      end
      sms_pkg::B_ROOT: begin
        rad  <= {rad[sms_pkg::RAD_BITS-3:0], 2'b00};
        rem  <= root_bit ? (rem_sh - trial) : rem_sh;
        root <= {root[sms_pkg::ROOT_BITS-2:0], root_bit};
        iter <= iter - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign totals.valid = out_valid;

endmodule

`default_nettype wire

// File: src/stroke_map_statistics.sv
// ----------------------------------------------------------------------------
// stroke_map_statistics: length, point count and bounding box of a stroke map
// Points arrive on the points channel; a map-end beat yields one totals beat.
// ----------------------------------------------------------------------------
// Use: drive beats on points (has_point, x_coord, y_coord, stroke flags,
// map_end). Each segment inside a stroke, and the closing segment of a closed
// stroke, adds floor(sqrt(dx^2 + dy^2)) to a saturating length sum. A beat with
// map_end set produces one beat on totals and then clears all statistics.
// Flow: the front end takes a beat, then pushes its queued operations (a
// segment, a closing segment, a map end) one at a time while the queue has
// room, and takes no new beat until all are pushed. The back end works on one
// segment at a time in the root unit, which retires two radicand bits per
// cycle, and takes the next only once the last is in the length sum. A map end
// passes from the front-end register through the queue to the totals register,
// once all segments still queued ahead of it have finished.
// A four-entry queue sits between the parts, so the front keeps taking beats
// while the back works. When totals is stalled, its register holds its value
// and a later map end waits at the head of the queue; segments queued ahead of
// it still finish, everything behind it waits, and once the queue is full the
// points channel drops ready.
// Reset (rst, synchronous) empties the queue and clears all statistics; ready
// on points stays low while rst is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_map_statistics (
  input  wire logic clk,
  input  wire logic rst,
  sms_in_if.sink    points,
  sms_out_if.source totals
);

  // Operation handed from the classifier to the queue.
  sms_pkg::op_t push_op;
  logic         push_valid;
  logic         queue_full;

  // Head of the queue, consumed by the length unit.
  sms_pkg::op_t head_op;
  logic         head_valid;
  logic         pop;

  // Front end: stroke tracking, point count, bounding box.
  sms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .push_op    (push_op),
    .push_valid (push_valid),
    .queue_full (queue_full)
  );

  // Decouples intake from the much slower root unit.
  sms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_op   (push_op),
    .full      (queue_full),
    .pop       (pop),
    .head_op   (head_op),
    .not_empty (head_valid)
  );

  // Back end: segment lengths, length sum and the totals register.
  sms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_op    (head_op),
    .head_valid (head_valid),
    .pop        (pop),
    .totals     (totals)
  );

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stroke_map_statistics
// Drives point beats through a short directed table and then random stroke
// maps. An in-bench model of the point count, polyline length and bounding box
// predicts every totals beat not given by hand in a directed row, and each
// is compared field by field as it leaves the block. Both channels idle at
// random, and once the receiver holds off until the block stalls its input.
// ----------------------------------------------------------------------------

module testbench;

  // Effective beats in the whole run. The last stretch has no idling.
  localparam int ITEM_TARGET  = 1350;
  localparam int QUIET_ITEMS  = 150;
  // The long receiver hold-off starts once this many beats have gone in.
  localparam int HOLD_AT_ITEM = 500;
  localparam int HOLD_CYCLES  = 600;
  // Enough for four queued segments to finish, with a good margin.
  localparam int DRAIN_CYCLES = 150;
  // The longest correct pause is the hold-off plus a full queue of segments.
  localparam int STALL_LIMIT  = 3000;

  typedef logic signed [sms_pkg::COORD_BITS-1:0] coord_t;

  // One beat on the points channel.
  typedef struct packed {
    logic   has_point;
    coord_t x_coord;
    coord_t y_coord;
    logic   stroke_start;
    logic   stroke_end;
    logic   stroke_closed;
    logic   map_end;
  } map_beat_t;

  // One beat on the totals channel.
  typedef struct packed {
    logic [sms_pkg::COUNT_BITS-1:0]  point_total;
    logic [sms_pkg::LENGTH_BITS-1:0] length_total;
    logic                            box_found;
    coord_t                          box_min_x;
    coord_t                          box_min_y;
    coord_t                          box_max_x;
    coord_t                          box_max_y;
  } map_totals_t;

  // A row of the directed table. Where fixed_want is set, the totals are
  // written out by hand in the row rather than taken from the model below.
  typedef struct {
    map_beat_t   beat;
    logic        fixed_want;
    map_totals_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  sms_in_if  points();
  sms_out_if totals();

  stroke_map_statistics u_top (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .totals (totals)
  );

  // Model of the map statistics. It mirrors what the block must hold: the
  // previous point, the first point of the open stroke (needed for the
  // closing segment), how many points the open stroke has, and the running
  // totals for the whole map.
  coord_t                          last_x, last_y;
  coord_t                          anchor_x, anchor_y;
  sms_pkg::seen_t                  stroke_pts;
  logic [sms_pkg::LENGTH_BITS-1:0] len_acc;
  logic [sms_pkg::COUNT_BITS-1:0]  pts_acc;
  coord_t                          lo_x, lo_y, hi_x, hi_y;
  logic                            any_pt;

  // Totals still owed by the block, oldest first.
  map_totals_t totals_due[$];

  int errors;
  int items_sent;
  int maps_checked;
  int segs_predicted;
  int holds_done;
  int stall_run;
  // Chance in percent that either side idles before its next beat.
  int idle_pct;
  bit hold_req;
  bit hold_issued;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // The state after reset, and again after every map end. The box starts
  // inverted so that the first point sets every edge of it.
  function automatic void clear_map_state();
    last_x     = '0;
    last_y     = '0;
    anchor_x   = '0;
    anchor_y   = '0;
    stroke_pts = sms_pkg::SEEN_NONE;
    len_acc    = '0;
    pts_acc    = '0;
    lo_x       = sms_pkg::COORD_MAXV;
    lo_y       = sms_pkg::COORD_MAXV;
    hi_x       = sms_pkg::COORD_MINV;
    hi_y       = sms_pkg::COORD_MINV;
    any_pt     = 1'b0;
  endfunction

  // Euclidean distance between two points, rounded down. The differences
  // reach 2^24 - 1, so the sum of squares needs 49 bits and the root 25;
  // a plain bit-by-bit search over the root is exact at these sizes.
  function automatic longint unsigned seg_root(input coord_t ax, input coord_t ay,
                                               input coord_t bx, input coord_t by);
    longint            dx;
    longint            dy;
    longint unsigned   rad;
    longint unsigned   root;
    longint unsigned   cand;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    rad  = longint'(dx * dx + dy * dy);
    root = 0;
    for (int b = sms_pkg::ROOT_BITS - 1; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= rad) root = cand;
    end
    return root;
  endfunction

  // The length sum sticks at all ones once it would overflow.
  function automatic void add_length(input longint unsigned seg);
    longint unsigned sum;
    sum = 64'(len_acc) + seg;
    if (sum > 64'(sms_pkg::LENGTH_MAX)) sum = 64'(sms_pkg::LENGTH_MAX);
    len_acc = sum[sms_pkg::LENGTH_BITS-1:0];
    segs_predicted++;
  endfunction

  // Applies one accepted beat to the model. Returns 1 and fills t when the
  // beat ends the map and so owes a totals beat.
  function automatic bit apply_beat(input map_beat_t b, output map_totals_t t);
    coord_t px;
    coord_t py;
    t  = '0;
    px = b.x_coord;
    py = b.y_coord;
    // A bare beat carries no point: its stroke flags mean nothing.
    if (b.has_point) begin
      // A point with no stroke open begins one even without stroke_start,
      // and stroke_start inside an open stroke drops that stroke silently.
      if (b.stroke_start || stroke_pts == sms_pkg::SEEN_NONE) begin
        anchor_x   = px;
        anchor_y   = py;
        stroke_pts = sms_pkg::SEEN_ONE;
      end else begin
        add_length(seg_root(last_x, last_y, px, py));
        stroke_pts = sms_pkg::SEEN_MANY;
      end
      last_x = px;
      last_y = py;
      // The closed flag only counts together with stroke_end. A closed
      // two-point stroke adds its single segment a second time.
      if (b.stroke_end) begin
        if (b.stroke_closed && stroke_pts == sms_pkg::SEEN_MANY)
          add_length(seg_root(last_x, last_y, anchor_x, anchor_y));
        stroke_pts = sms_pkg::SEEN_NONE;
      end
      if (pts_acc != sms_pkg::COUNT_MAX) pts_acc = pts_acc + 1'b1;
      if (px < lo_x) lo_x = px;
      if (py < lo_y) lo_y = py;
      if (px > hi_x) hi_x = px;
      if (py > hi_y) hi_y = py;
      any_pt = 1'b1;
    end
    // A map end inside an open stroke simply closes the books on it: no
    // closing segment is added.
    if (!b.map_end) return 1'b0;
    t.point_total  = pts_acc;
    t.length_total = len_acc;
    t.box_found    = any_pt;
    if (any_pt) begin
      t.box_min_x = lo_x;
      t.box_min_y = lo_y;
      t.box_max_x = hi_x;
      t.box_max_y = hi_y;
    end
    clear_map_state();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic map_beat_t beat_of(input bit hp, input coord_t x, input coord_t y,
                                        input bit s, input bit e, input bit c, input bit m);
    map_beat_t b;
    b.has_point     = hp;
    b.x_coord       = x;
    b.y_coord       = y;
    b.stroke_start  = s;
    b.stroke_end    = e;
    b.stroke_closed = c;
    b.map_end       = m;
    return b;
  endfunction

  function automatic map_totals_t totals_of(input int n, input longint len, input bit found,
                                            input coord_t mnx, input coord_t mny,
                                            input coord_t mxx, input coord_t mxy);
    map_totals_t t;
    t.point_total  = sms_pkg::COUNT_BITS'(n);
    t.length_total = sms_pkg::LENGTH_BITS'(len);
    t.box_found    = found;
    t.box_min_x    = mnx;
    t.box_min_y    = mny;
    t.box_max_x    = mxx;
    t.box_max_y    = mxy;
    return t;
  endfunction

  // A signed step of up to 2^bits - 1 in either direction.
  function automatic coord_t jitter(input int bits);
    int mag;
    mag = $urandom_range(0, (1 << bits) - 1);
    return $urandom_range(0, 1) ? coord_t'(-mag) : coord_t'(mag);
  endfunction

  // Offers one beat and waits until it is taken. Called at a rising edge and
  // returns at the edge of acceptance, so valid stays high from one beat to
  // the next with no gap unless an idle burst is drawn. The model is then
  // stepped, and any totals owed are queued: from the model, or from the
  // row itself where a directed row gives them by hand.
  task automatic send_beat(input map_beat_t b, input bit use_fixed = 1'b0,
                           input map_totals_t fixed_want = '0);
    map_totals_t t;
    int          gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid         <= 1'b1;
    points.has_point     <= b.has_point;
    points.x_coord       <= b.x_coord;
    points.y_coord       <= b.y_coord;
    points.stroke_start  <= b.stroke_start;
    points.stroke_end    <= b.stroke_end;
    points.stroke_closed <= b.stroke_closed;
    points.map_end       <= b.map_end;
    do @(posedge clk); while (points.ready !== 1'b1);
    // A bare beat without map_end does nothing, so it is not counted.
    if (b.has_point || b.map_end) items_sent++;
    if (apply_beat(b, t)) totals_due.push_back(use_fixed ? fixed_want : t);
    if (!hold_issued && items_sent >= HOLD_AT_ITEM) begin
      hold_issued = 1'b1;
      hold_req    = 1'b1;
    end
  endtask

  // A well-formed map with random content: one to four strokes, mostly short,
  // either around a random centre with steps of random size or scattered
  // over the full coordinate range. A few strokes lose their start or end
  // flag, or end early, so that the implicit start and the dropped stroke
  // also turn up inside otherwise regular maps. The map ends either on its
  // last point or on a bare marker with random flags.
  task automatic send_random_map();
    map_beat_t b;
    int        n_strokes;
    int        n_pts;
    int        span;
    bit        wide;
    bit        last_pt;
    bit        end_on_point;
    coord_t    cx;
    coord_t    cy;
    n_strokes    = $urandom_range(1, 4);
    end_on_point = 1'($urandom_range(0, 1));
    for (int s = 0; s < n_strokes; s++) begin
      n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      wide  = ($urandom_range(0, 4) == 0);
      span  = $urandom_range(0, 12);
      cx    = coord_t'($urandom);
      cy    = coord_t'($urandom);
      for (int p = 0; p < n_pts; p++) begin
        if (p != 0) begin
          if (wide) begin
            cx = coord_t'($urandom);
            cy = coord_t'($urandom);
          end else begin
            cx = cx + jitter(span);
            cy = cy + jitter(span);
          end
        end
        last_pt         = (p == n_pts - 1);
        b.has_point     = 1'b1;
        b.x_coord       = cx;
        b.y_coord       = cy;
        b.stroke_start  = (p == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        b.stroke_end    = last_pt ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 29) == 0);
        b.stroke_closed = 1'($urandom_range(0, 1));
        b.map_end       = last_pt && (s == n_strokes - 1) && end_on_point;
        send_beat(b);
      end
    end
    if (!end_on_point) begin
      b           = beat_of(1'b0, coord_t'($urandom), coord_t'($urandom),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b1);
      send_beat(b);
    end
  endtask

  // A beat with every field drawn at random; map ends are kept rare so that
  // noise does not chop the regular maps into pieces.
  task automatic send_noise();
    map_beat_t b;
    b = beat_of(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    send_beat(b);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t  dir_tbl[$];
    map_beat_t b;
    int        next_shift;

    rst                  = 1'b1;
    points.valid         = 1'b0;
    points.has_point     = 1'b0;
    points.x_coord       = '0;
    points.y_coord       = '0;
    points.stroke_start  = 1'b0;
    points.stroke_end    = 1'b0;
    points.stroke_closed = 1'b0;
    points.map_end       = 1'b0;
    errors               = 0;
    items_sent           = 0;
    maps_checked         = 0;
    segs_predicted       = 0;
    holds_done           = 0;
    idle_pct             = 0;
    hold_req             = 1'b0;
    hold_issued          = 1'b0;
    clear_map_state();

    // Directed table. Each line is one beat:
    // has_point, x, y, stroke_start, stroke_end, stroke_closed, map_end.

    // A map end straight after reset: an empty map, box reported as zero.
    dir_tbl.push_back('{beat_of(0, 0, 0, 0, 0, 0, 1), 1'b1, totals_of(0, 0, 0, 0, 0, 0, 0)});
    // A bare beat with every stroke flag set and no map end: no effect.
    dir_tbl.push_back('{beat_of(0, sms_pkg::COORD_MINV, sms_pkg::COORD_MAXV, 1, 1, 1, 0),
                        1'b0, '0});
    // A single-point closed stroke has no length, even with the closed flag.
    dir_tbl.push_back('{beat_of(1, sms_pkg::COORD_MAXV, sms_pkg::COORD_MINV, 1, 1, 1, 1), 1'b1,
                        totals_of(1, 0, 1, sms_pkg::COORD_MAXV, sms_pkg::COORD_MINV,
                                  sms_pkg::COORD_MAXV, sms_pkg::COORD_MINV)});
    // Corner to corner and back: the largest segment, counted twice because
    // a closed two-point stroke adds its closing segment as well.
    dir_tbl.push_back('{beat_of(1, sms_pkg::COORD_MINV, sms_pkg::COORD_MINV, 1, 0, 0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{beat_of(1, sms_pkg::COORD_MAXV, sms_pkg::COORD_MAXV, 0, 1, 1, 1),
                        1'b0, '0});
    // A closed 3-4-5 triangle.
    dir_tbl.push_back('{beat_of(1, 0, 0, 1, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 3, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 3, 4, 0, 1, 1, 1), 1'b1, totals_of(3, 12, 1, 0, 0, 3, 4)});
    // A point with no stroke open and no start flag opens a stroke, an open
    // end gives no closing segment, the closed flag without an end is
    // ignored, and the map ends while a stroke is still open.
    dir_tbl.push_back('{beat_of(1, -5, 7, 0, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, -5, 10, 0, 1, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 1, 1, 0, 0, 1, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 4, 5, 0, 0, 1, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(0, 9, 9, 1, 1, 1, 1), 1'b0, '0});
    // A start inside an open stroke drops it; the new two-point stroke is
    // closed, so 10 along the first, then 10 and 10 again.
    dir_tbl.push_back('{beat_of(1, 0, 0, 1, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 10, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 100, 100, 1, 0, 1, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 100, 110, 0, 1, 1, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(0, 0, 0, 0, 0, 0, 1), 1'b1, totals_of(4, 30, 1, 0, 0, 100, 110)});
    // A bare map end with all its point flags set: still an empty map.
    dir_tbl.push_back('{beat_of(0, sms_pkg::COORD_MAXV, sms_pkg::COORD_MINV, 1, 1, 1, 1), 1'b1,
                        totals_of(0, 0, 0, 0, 0, 0, 0)});
    // One point, no start flag, at the opposite corner.
    dir_tbl.push_back('{beat_of(1, sms_pkg::COORD_MINV, sms_pkg::COORD_MAXV, 0, 1, 1, 1), 1'b1,
                        totals_of(1, 0, 1, sms_pkg::COORD_MINV, sms_pkg::COORD_MAXV,
                                  sms_pkg::COORD_MINV, sms_pkg::COORD_MAXV)});
    // A unit diagonal across zero, closed: both segments round down to 1.
    dir_tbl.push_back('{beat_of(1, -1, 0, 1, 0, 0, 0), 1'b0, '0});
    dir_tbl.push_back('{beat_of(1, 0, -1, 0, 1, 1, 1), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i])
      send_beat(dir_tbl[i].beat, dir_tbl[i].fixed_want, dir_tbl[i].want);

    // Random maps mixed with noise beats, with the idling level redrawn every 80 beats so that
    // busy stretches alternate with calm ones, and none at all at the end.
    next_shift = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
        idle_pct = 0;
      end else if (items_sent >= next_shift) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
        next_shift = items_sent + 80;
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_map();
    end
    // Close whatever map is still open so its totals are checked too.
    b = beat_of(0, 0, 0, 0, 0, 0, 1);
    send_beat(b);
    points.valid <= 1'b0;

    // Wait for every owed totals beat, then a while longer in case the
    // block sends something it should not.
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d point beats and %0d segment lengths over %0d checked maps.",
             items_sent, segs_predicted, maps_checked);
    $display("Long receiver hold-offs: %0d; mismatches: %0d.", holds_done, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Totals receiver: random short stalls, plus the one long hold-off that
  // lets map ends pile up in the block until it refuses further beats.
  // --------------------------------------------------------------------------
  initial begin : totals_sink
    int gap;
    totals.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        totals.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 6);
        totals.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        totals.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Values are read at the rising edge, before this edge's updates land, so
  // the beat seen is the one that the edge accepts.
  always @(posedge clk) begin : totals_check
    map_totals_t want;
    if (!rst && totals.valid && totals.ready) begin
      if (totals_due.size() == 0) begin
        $display("%0t: totals beat with no map end pending, expected none, actual %0d points",
                 $time, totals.point_total);
        errors++;
      end else begin
        want = totals_due.pop_front();
        check_field("point_total", 64'(want.point_total), 64'(totals.point_total));
        check_field("length_total", 64'(want.length_total), 64'(totals.length_total));
        check_field("box_found", 64'(want.box_found), 64'(totals.box_found));
        check_field("box_min_x", 64'(want.box_min_x), 64'(totals.box_min_x));
        check_field("box_min_y", 64'(want.box_min_y), 64'(totals.box_min_y));
        check_field("box_max_x", 64'(want.box_max_x), 64'(totals.box_max_x));
        check_field("box_max_y", 64'(want.box_max_y), 64'(totals.box_max_y));
        maps_checked++;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (points.valid && points.ready) || (totals.valid && totals.ready)) begin
      stall_run <= 0;
    end else if (stall_run >= STALL_LIMIT) begin
      $display("%0t: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

endmodule

// File: filelist.f
src/sms_pkg.sv
src/sms_if.sv
src/sms_front.sv
src/sms_queue.sv
src/sms_back.sv
src/stroke_map_statistics.sv
dv/testbench.sv
